// ===== design/alrp_pkg.sv =====
// Shared types and constants for the ASCII load record parser.
package alrp_pkg;

  localparam int CharW   = 8;
  localparam int KindW   = 2;
  localparam int AddrW   = 18;
  localparam int WordW   = 36;
  localparam int ZcntW   = 17;
  localparam int TokW    = 16;
  localparam int CountW  = 14;
  localparam int ThirdW  = 13;
  localparam int RecipW  = 16;
  localparam int RecipSh = 17;

  localparam logic [CharW-1:0]  ChNewline = 8'h0A;
  localparam logic [CharW-1:0]  ChComma   = 8'h2C;
  localparam logic [CharW-1:0]  ChSemi    = 8'h3B;
  localparam logic [CharW-1:0]  ChT       = 8'h54;
  localparam logic [CharW-1:0]  ChZ       = 8'h5A;
  localparam logic [TokW-1:0]   HighMask  = 16'hC000;
  localparam logic [RecipW-1:0] RecipThree = 16'hAAAB;
  localparam logic [ZcntW-1:0]  ZeroFull  = 17'h10000;

  typedef enum logic [3:0] {
    PH_TYPE   = 4'd0,
    PH_BLANK  = 4'd1,
    PH_COUNT  = 4'd2,
    PH_ADDR   = 4'd3,
    PH_ZCOUNT = 4'd4,
    PH_D0     = 4'd5,
    PH_D1     = 4'd6,
    PH_D2     = 4'd7,
    PH_SKIP   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    REC_T     = 2'd0,
    REC_Z     = 2'd1,
    REC_OTHER = 2'd3
  } rec_kind_t;

  typedef enum logic [KindW-1:0] {
    OUT_WRITE = 2'd0,
    OUT_ZERO  = 2'd1,
    OUT_START = 2'd2,
    OUT_ERROR = 2'd3
  } out_kind_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] address;
    logic [WordW-1:0] data_word;
    logic [ZcntW-1:0] zero_count;
  } result_t;

endpackage

// ===== design/alrp_in_stage.sv =====
// Input register holding one character transfer ahead of the parser step.
module alrp_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [alrp_pkg::CharW-1:0] char_in,
  input  logic                       advance,
  output logic                       held,
  output logic [alrp_pkg::CharW-1:0] held_ch
);
  import alrp_pkg::*;

  logic accept;

  assign in_stall = held && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_ch <= char_in;
    end
  end

endmodule

// ===== design/alrp_step.sv =====
// Parser state and per-character next-state and result logic.
module alrp_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [alrp_pkg::CharW-1:0] ch,
  output alrp_pkg::result_t          res
);
  import alrp_pkg::*;

  phase_t                  phase, phase_next;
  rec_kind_t               record_kind, record_kind_next;
  logic [TokW-1:0]         token_acc, token_acc_next;
  logic [CountW-1:0]       word_count, word_count_next;
  logic [ThirdW-1:0]       word_thirds, word_thirds_next;
  logic [TokW-1:0]         record_addr, record_addr_next;
  logic [CountW-1:0]       word_index, word_index_next;
  logic [TokW-1:0]         low_part, low_part_next;
  logic [TokW-1:0]         mid_part, mid_part_next;
  logic                    line_ended, line_ended_next;

  logic                    nl, delim;
  logic [TokW-1:0]         addr_full;
  logic [CountW+RecipW-1:0] prod;
  logic [CountW-1:0]       index_inc;
  phase_t                  end_phase;

  always_comb begin
    nl        = (ch == ChNewline);
    delim     = nl || (ch == ChComma);
    addr_full = record_addr | token_acc;
    prod      = token_acc[CountW-1:0] * RecipThree;
    index_inc = word_index + CountW'(1);
    end_phase = nl ? PH_TYPE : PH_SKIP;

    phase_next       = phase;
    record_kind_next = record_kind;
    token_acc_next   = token_acc;
    word_count_next  = word_count;
    word_thirds_next = word_thirds;
    record_addr_next = record_addr;
    word_index_next  = word_index;
    low_part_next    = low_part;
    mid_part_next    = mid_part;
    line_ended_next  = line_ended;
    res              = '0;

    case (phase)
      PH_BLANK: begin
        phase_next = nl ? PH_TYPE : PH_COUNT;
      end
      PH_SKIP: begin
        if (nl) phase_next = PH_TYPE;
      end
      PH_COUNT, PH_ADDR, PH_ZCOUNT, PH_D0, PH_D1, PH_D2: begin
        if (!delim) begin
          token_acc_next = {token_acc[TokW-7:0], ch[5:0]};
        end else begin
          token_acc_next  = '0;
          line_ended_next = nl;
          case (phase)
            PH_COUNT: begin
              word_count_next  = token_acc[CountW-1:0];
              word_thirds_next = prod[RecipSh +: ThirdW];
              record_addr_next = token_acc & HighMask;
              phase_next       = nl ? PH_TYPE : PH_ADDR;
            end
            PH_ADDR: begin
              record_addr_next = addr_full;
              if (record_kind == REC_OTHER) begin
                res.valid   = 1'b1;
                res.kind    = OUT_ERROR;
                res.address = AddrW'(addr_full);
                phase_next  = end_phase;
              end else if (record_kind == REC_Z) begin
                phase_next = nl ? PH_TYPE : PH_ZCOUNT;
              end else if (word_count == '0) begin
                res.valid   = 1'b1;
                res.kind    = OUT_START;
                res.address = AddrW'(addr_full);
                phase_next  = end_phase;
              end else if (word_thirds == '0) begin
                phase_next = end_phase;
              end else begin
                phase_next = nl ? PH_TYPE : PH_D0;
              end
            end
            PH_ZCOUNT: begin
              res.valid      = 1'b1;
              res.kind       = OUT_ZERO;
              res.address    = AddrW'(record_addr);
              res.zero_count = (token_acc == '0) ? ZeroFull : ZcntW'(token_acc);
              phase_next     = end_phase;
            end
            PH_D0: begin
              low_part_next = token_acc;
              phase_next    = nl ? PH_TYPE : PH_D1;
            end
            PH_D1: begin
              mid_part_next = token_acc;
              phase_next    = nl ? PH_TYPE : PH_D2;
            end
            default: begin
              res.valid       = 1'b1;
              res.kind        = OUT_WRITE;
              res.address     = AddrW'(record_addr) + AddrW'(word_index);
              res.data_word   = {token_acc[3:0], mid_part, low_part};
              word_index_next = index_inc;
              if (index_inc >= CountW'(word_thirds)) phase_next = end_phase;
              else phase_next = nl ? PH_TYPE : PH_D0;
            end
          endcase
        end
      end
      default: begin
        if (nl) begin
          phase_next = PH_TYPE;
        end else if (ch == ChSemi) begin
          phase_next = PH_SKIP;
        end else begin
          record_kind_next = (ch == ChT) ? REC_T : ((ch == ChZ) ? REC_Z : REC_OTHER);
          token_acc_next   = '0;
          word_index_next  = '0;
          line_ended_next  = 1'b0;
          phase_next       = PH_BLANK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      record_kind <= REC_T;
      token_acc   <= '0;
      word_count  <= '0;
      word_thirds <= '0;
      record_addr <= '0;
      word_index  <= '0;
      low_part    <= '0;
      mid_part    <= '0;
      line_ended  <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      record_kind <= record_kind_next;
      token_acc   <= token_acc_next;
      word_count  <= word_count_next;
      word_thirds <= word_thirds_next;
      record_addr <= record_addr_next;
      word_index  <= word_index_next;
      low_part    <= low_part_next;
      mid_part    <= mid_part_next;
      line_ended  <= line_ended_next;
    end
  end

endmodule

// ===== design/alrp_out_reg.sv =====
// Result register driving the output channel.
module alrp_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  alrp_pkg::result_t          res,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [alrp_pkg::KindW-1:0] kind,
  output logic [alrp_pkg::AddrW-1:0] address,
  output logic [alrp_pkg::WordW-1:0] data_word,
  output logic [alrp_pkg::ZcntW-1:0] zero_count
);
  import alrp_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      kind       <= res.kind;
      address    <= res.address;
      data_word  <= res.data_word;
      zero_count <= res.zero_count;
    end
  end

endmodule

// ===== design/ascii_load_record_parser_top.sv =====
// Top level of the ASCII load record parser.
//
//   channel | signals                                                    | per transfer
//   input   | in_valid, in_stall, char_in                                | one character
//   output  | out_valid, out_stall, kind, address, data_word, zero_count | at most one result
//
// One character per cycle sustained while the output is not stalled; a result reaches the
// output from its character transfer through the input register, then the result register.
// Reset clears the parser to waiting for a record type and empties both registers.
// Output stall holds the result register; the input register keeps accepting
// while the result register can take the parsed character.
module ascii_load_record_parser_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [alrp_pkg::CharW-1:0] char_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [alrp_pkg::KindW-1:0] kind,
  output logic [alrp_pkg::AddrW-1:0] address,
  output logic [alrp_pkg::WordW-1:0] data_word,
  output logic [alrp_pkg::ZcntW-1:0] zero_count
);
  import alrp_pkg::*;

  logic              held;
  logic [CharW-1:0]  held_ch;
  logic              free;
  logic              advance;
  result_t           res;

  assign advance = held && free;

  alrp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_in  (char_in),
    .advance  (advance),
    .held     (held),
    .held_ch  (held_ch)
  );

  alrp_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ch      (held_ch),
    .res     (res)
  );

  alrp_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .res        (res),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .address    (address),
    .data_word  (data_word),
    .zero_count (zero_count)
  );

endmodule

// ===== design/alrp_checker.sv =====
// Port-level assertions for the ASCII load record parser, bound to the top level.
module alrp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [alrp_pkg::CharW-1:0] char_in,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [alrp_pkg::KindW-1:0] kind,
  input logic [alrp_pkg::AddrW-1:0] address,
  input logic [alrp_pkg::WordW-1:0] data_word,
  input logic [alrp_pkg::ZcntW-1:0] zero_count
);
  import alrp_pkg::*;

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^char_in);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(address)
      && $stable(data_word) && $stable(zero_count))
    else $error("stalled result changed");

  a_data_only_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != OUT_WRITE) |-> data_word == '0)
    else $error("data word set on non-write result");

  a_zcount_only_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != OUT_ZERO) |-> zero_count == '0)
    else $error("zero count set on non-zero-range result");

  a_zcount_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == OUT_ZERO) |-> (zero_count != '0) && (zero_count <= ZeroFull))
    else $error("zero count out of range");

  a_addr_narrow: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != OUT_WRITE) |-> address[AddrW-1:TokW] == '0)
    else $error("record address exceeds 16 bits");

endmodule

bind ascii_load_record_parser_top alrp_checker u_alrp_checker (.*);

// ===== sim/ascii_load_record_parser_top_tb.sv =====
// Testbench for the load record parser: streams load lines and checks every emitted record.
module ascii_load_record_parser_top_tb;
  import alrp_pkg::*;

  localparam int TotalChars = 1050;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] address;
    logic [WordW-1:0] data_word;
    logic [ZcntW-1:0] zero_count;
  } load_record_t;

  class load_record_tracker;
    phase_t              ph;
    rec_kind_t           rk;
    logic [TokW-1:0]     acc;
    logic [TokW-1:0]     raddr;
    logic [TokW-1:0]     lowp;
    logic [TokW-1:0]     midp;
    logic [CountW-1:0]   wcount;
    logic [CountW-1:0]   widx;
    logic                lend;
    load_record_t        pending_records[$];
    int                  errors;

    function new();
      ph = PH_TYPE;
      rk = REC_T;
      acc = '0;
      raddr = '0;
      lowp = '0;
      midp = '0;
      wcount = '0;
      widx = '0;
      lend = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    function void push(out_kind_t k, logic [AddrW-1:0] a, logic [WordW-1:0] d,
                       logic [ZcntW-1:0] z);
      load_record_t r;
      r.kind = k;
      r.address = a;
      r.data_word = d;
      r.zero_count = z;
      pending_records.push_back(r);
    endfunction

    function void finish_record();
      ph = lend ? PH_TYPE : PH_SKIP;
    endfunction

    // advance the parser by one accepted character
    function void take_char(logic [CharW-1:0] ch);
      logic            nl;
      logic            delim;
      logic [TokW-1:0] val;
      nl = (ch == ChNewline);
      delim = nl || (ch == ChComma);
      case (ph)
        PH_BLANK: begin
          ph = nl ? PH_TYPE : PH_COUNT;
          return;
        end
        PH_SKIP: begin
          if (nl) ph = PH_TYPE;
          return;
        end
        PH_COUNT, PH_ADDR, PH_ZCOUNT, PH_D0, PH_D1, PH_D2: ;
        default: begin
          if (nl) begin
            ph = PH_TYPE;
          end else if (ch == ChSemi) begin
            ph = PH_SKIP;
          end else begin
            rk = (ch == ChT) ? REC_T : ((ch == ChZ) ? REC_Z : REC_OTHER);
            acc = '0;
            widx = '0;
            lend = 1'b0;
            ph = PH_BLANK;
          end
          return;
        end
      endcase

      if (!delim) begin
        acc = {acc[TokW-7:0], ch[5:0]};
        return;
      end
      val = acc;
      acc = '0;
      lend = nl;

      case (ph)
        PH_COUNT: begin
          wcount = val[CountW-1:0];
          raddr = val & HighMask;
          ph = nl ? PH_TYPE : PH_ADDR;
        end
        PH_ADDR: begin
          raddr = raddr | val;
          if (rk == REC_OTHER) begin
            push(OUT_ERROR, {2'b00, raddr}, '0, '0);
            finish_record();
          end else if (rk == REC_Z) begin
            ph = nl ? PH_TYPE : PH_ZCOUNT;
          end else if (wcount == 0) begin
            push(OUT_START, {2'b00, raddr}, '0, '0);
            finish_record();
          end else if (wcount / 3 == 0) begin
            finish_record();
          end else begin
            ph = nl ? PH_TYPE : PH_D0;
          end
        end
        PH_ZCOUNT: begin
          push(OUT_ZERO, {2'b00, raddr}, '0, (val == 0) ? ZeroFull : {1'b0, val});
          finish_record();
        end
        PH_D0: begin
          lowp = val;
          ph = nl ? PH_TYPE : PH_D1;
        end
        PH_D1: begin
          midp = val;
          ph = nl ? PH_TYPE : PH_D2;
        end
        default: begin
          push(OUT_WRITE, {2'b00, raddr} + {4'b0000, widx}, {val[3:0], midp, lowp}, '0);
          widx = widx + 1'b1;
          if (widx >= wcount / 3) finish_record();
          else ph = nl ? PH_TYPE : PH_D0;
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_record(logic [KindW-1:0] k, logic [AddrW-1:0] a, logic [WordW-1:0] d,
                      logic [ZcntW-1:0] z);
      load_record_t e;
      if (pending_records.size() == 0) begin
        report($sformatf("record with none pending: kind %0d address %h", k, a));
        return;
      end
      e = pending_records.pop_front();
      if (k !== e.kind)
        report($sformatf("kind %0d, want %0d", k, e.kind));
      if (a !== e.address)
        report($sformatf("address %h, want %h", a, e.address));
      if (d !== e.data_word)
        report($sformatf("data_word %h, want %h", d, e.data_word));
      if (z !== e.zero_count)
        report($sformatf("zero_count %h, want %h", z, e.zero_count));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CharW-1:0]   char_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KindW-1:0]   kind;
  logic [AddrW-1:0]   address;
  logic [WordW-1:0]   data_word;
  logic [ZcntW-1:0]   zero_count;

  load_record_tracker tracker = new();
  bit [CharW-1:0]     line_q[$];
  int                 sent = 0;
  int                 cycle_count = 0;
  int                 hold_left = 0;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;

  ascii_load_record_parser_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .address    (address),
    .data_word  (data_word),
    .zero_count (zero_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[ascii_load_record_parser_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_record(kind, address, data_word, zero_count);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  function automatic bit [CharW-1:0] plain_char();
    bit [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255)); while (c == ChNewline || c == ChComma);
    return c;
  endfunction

  function automatic bit [CharW-1:0] skip_char();
    bit [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255)); while (c == ChNewline);
    return c;
  endfunction

  function automatic bit [CharW-1:0] char_low6(bit [5:0] v);
    bit [CharW-1:0] c;
    bit [1:0]       top;
    do begin
      top = 2'($urandom_range(0, 3));
      c = {top, v};
    end while (c == ChNewline || c == ChComma);
    return c;
  endfunction

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_plain(int n);
    repeat (n) line_q.push_back(plain_char());
  endtask

  // count token of value n, sometimes carrying address high bits
  task automatic add_count(int n);
    bit [CharW-1:0] c1;
    bit [3:0]       hi;
    bit [1:0]       sel;
    if ($urandom_range(0, 3) == 0) begin
      do begin
        hi = 4'($urandom_range(0, 15));
        sel = 2'($urandom_range(1, 3));
        c1 = {hi, sel, 2'b00};
      end while (c1 == ChComma);
      line_q.push_back(c1);
      line_q.push_back(char_low6(6'd0));
      line_q.push_back(char_low6(n[5:0]));
    end else if (n == 0 && $urandom_range(0, 1) == 0) begin
      // empty token reads as zero
    end else begin
      if ($urandom_range(0, 2) == 0) line_q.push_back(char_low6(6'd0));
      line_q.push_back(char_low6(n[5:0]));
    end
  endtask

  task automatic end_line();
    if ($urandom_range(0, 1) == 0) begin
      line_q.push_back(ChNewline);
    end else begin
      line_q.push_back(ChComma);
      repeat ($urandom_range(0, 4)) line_q.push_back(skip_char());
      line_q.push_back(ChNewline);
    end
  endtask

  task automatic add_header(bit [CharW-1:0] type_ch, int n);
    line_q.push_back(type_ch);
    line_q.push_back(skip_char());
    add_count(n);
    line_q.push_back(ChComma);
    add_plain($urandom_range(0, 3));
  endtask

  task automatic gen_line();
    int             r;
    int             n;
    int             nw;
    int             broken;
    bit [CharW-1:0] t;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      nw = (n / 3) * 3;
      add_header(ChT, n);
      if (nw == 0) begin
        end_line();
      end else if ($urandom_range(0, 19) == 0) begin
        line_q.push_back(ChNewline);
      end else begin
        broken = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nw - 1) : -1;
        line_q.push_back(ChComma);
        for (int i = 0; i < nw; i++) begin
          add_plain($urandom_range(0, 3));
          if (i == broken) begin
            line_q.push_back(ChNewline);
            break;
          end
          if (i < nw - 1) line_q.push_back(ChComma);
          else end_line();
        end
      end
    end else if (r < 60) begin
      add_header(ChT, 0);
      end_line();
    end else if (r < 72) begin
      add_header(ChZ, $urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(ChNewline);
      end else begin
        line_q.push_back(ChComma);
        add_plain($urandom_range(0, 3));
        end_line();
      end
    end else if (r < 80) begin
      do t = plain_char(); while (t == ChT || t == ChZ || t == ChSemi);
      add_header(t, $urandom_range(0, 15));
      end_line();
    end else if (r < 86) begin
      line_q.push_back(ChSemi);
      repeat ($urandom_range(0, 6)) line_q.push_back(skip_char());
      line_q.push_back(ChNewline);
    end else if (r < 89) begin
      line_q.push_back(ChNewline);
    end else begin
      repeat ($urandom_range(1, 12)) line_q.push_back(CharW'($urandom_range(0, 255)));
      line_q.push_back(ChNewline);
    end
  endtask

  task automatic send_char(bit [CharW-1:0] ch);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in <= ch;
    do @(posedge clk); while (in_stall);
    tracker.take_char(ch);
    sent++;
  endtask

  task automatic send_line();
    while (line_q.size() > 0) send_char(line_q.pop_front());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  initial begin
    bit paused;
    bit held;
    paused = 1'b0;
    held = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    add_str("\n");
    add_str(";");
    line_q.push_back(8'hFF);
    add_str("\nT\nT \nQ");
    line_q.push_back(8'h00);
    add_str(",");
    repeat (3) line_q.push_back(8'hFF);
    add_str("\nT ,?,x\nZ ,,\nZ ,\nT ");
    line_q.push_back(8'h03);
    add_str(",A\nT ");
    line_q.push_back(8'h02);
    add_str(",E\nT ");
    line_q.push_back(8'h0C);
    line_q.push_back(8'h00);
    line_q.push_back(8'h03);
    add_str(",A,");
    repeat (3) line_q.push_back(8'hFF);
    add_str(",");
    repeat (3) line_q.push_back(8'hFF);
    add_str(",");
    repeat (2) line_q.push_back(8'hFF);
    add_str("\nT 6,,A,B\n");
    send_line();

    while (sent < TotalChars) begin
      calm = (sent >= 150 && sent < 350);
      if (!paused && sent >= 400) begin
        paused = 1'b1;
        drain();
      end
      if (!held && sent >= 600) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      gen_line();
      send_line();
    end
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ascii_load_record_parser_top] OK");
    end else begin
      $display("[ascii_load_record_parser_top] ERROR");
    end
    $finish;
  end

endmodule
